### hdl/snet_pkg.sv
// snet_pkg: shared types and constants of the sobel edge thinning unit
// no dependencies; used by every module of the block except snet_fifo
`timescale 1ns / 1ps
`default_nettype none

package snet_pkg;

  localparam int PIX_W  = 8;
  localparam int MAG_W  = 11;
  localparam int SECT_W = 2;
  localparam int CLS_W  = 2;
  localparam int GRAD_W = MAG_W + SECT_W;
  localparam int PROD_W = 36;
  localparam int TAN_SHIFT = 24;

  localparam logic [MAG_W-1:0] MAG_MAX = 11'd2040;

  // tan 22.5 and tan 67.5 in q8.24
  localparam logic [PROD_W-1:0] TAN_LO = 36'd6949350;
  localparam logic [PROD_W-1:0] TAN_HI = 36'd40503782;

  localparam logic [SECT_W-1:0] SECT_HORZ    = 2'd0;
  localparam logic [SECT_W-1:0] SECT_VERT    = 2'd1;
  localparam logic [SECT_W-1:0] SECT_MINUS45 = 2'd2;
  localparam logic [SECT_W-1:0] SECT_PLUS45  = 2'd3;

  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WEAK   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_STRONG = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd3;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [10:0] LOW_RST    = 11'd20;
  localparam logic [10:0] HIGH_RST   = 11'd60;

  // per-word control decided by the front end
  typedef struct packed {
    logic pix_en;   // pixel window shifts
    logic pix_wr;   // real pixel, line buffers written
    logic grad_en;  // gradient window shifts
    logic q_valid;  // gradient point inside the image
    logic q_col0;
    logic q_colw;
    logic q_row0;
    logic q_rowh;
    logic out_en;   // word produces a result
    logic t_col0;
    logic t_colw;
    logic t_row0;
    logic t_rowh;
    logic t_last;
  } cmd_flags_t;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic [SECT_W-1:0] sector;
    logic [CLS_W-1:0]  edge_class;
    logic              frame_last;
  } res_t;

endpackage

`default_nettype wire

### hdl/sobel_nonmax_edge_thinning_unit.sv
// sobel_nonmax_edge_thinning_unit: top level of the edge thinning block
// depends on snet_pkg, snet_front, snet_fifo and snet_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit grey pixel per clock while full is low, in raster
// order, and returns, per pixel, the non-maximum-suppressed L1 sobel
// magnitude, its direction sector and a none/weak/strong class. Borders
// replicate for sobel and read zero for suppression. The result for raster
// pixel p leaves after input word p+2W+2; after the W*H pixels of a frame
// send 2W+2 drain words (req_type 1) to flush the tail, then the next
// frame starts. Sustained rate is one word per clock while the output
// queue has room: the front end counts frame position and classifies each
// word, a four entry queue hands it to a five stage back end (pixel line
// buffers, sobel, sector compare, gradient line buffers, suppression),
// each line buffer one read and one write port per clock. Results sit in
// an eight entry output queue, which they enter from the suppression
// stage. Width or height writes restart the frame; write configuration
// only while the block is idle.

module sobel_nonmax_edge_thinning_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input word channel
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              in_req_type,
  input  wire logic [snet_pkg::PIX_W-1:0]        in_pixel,
  // result word channel
  output logic                                   empty,
  input  wire logic                              pop,
  output logic      [snet_pkg::MAG_W-1:0]        out_magnitude,
  output logic      [snet_pkg::SECT_W-1:0]       out_sector,
  output logic      [snet_pkg::CLS_W-1:0]        out_edge_class,
  output logic                                   out_frame_last,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [snet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [snet_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int CQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;
  localparam int FW       = $bits(snet_pkg::cmd_flags_t);
  localparam int CQ_W     = FW + snet_pkg::PIX_W + CW + CW;
  localparam int RES_W    = $bits(snet_pkg::res_t);

  // front end to queue
  logic                          in_acc, cmd_push;
  snet_pkg::cmd_flags_t          fe_flags, be_flags;
  logic [snet_pkg::PIX_W-1:0]    fe_pixel, be_pixel;
  logic [CW-1:0]                 fe_pcol, fe_qcol, be_pcol, be_qcol;
  logic [CQ_W-1:0]               cq_wdata, cq_rdata;
  logic                          cq_empty, cq_full, cmd_pop;
  logic [$clog2(CQ_DEPTH+1)-1:0] cq_count;
  // thresholds
  logic [snet_pkg::MAG_W-1:0]    low_thr, high_thr;
  // back end to result queue
  logic                          res_push;
  snet_pkg::res_t                res_in, res_out;
  logic [$clog2(OQ_DEPTH+1)-1:0] oq_count;
  logic                          oq_full;

  assign full   = cq_full;
  assign in_acc = push && !cq_full;

  snet_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_acc      (in_acc),
    .in_req_type (in_req_type),
    .in_pixel    (in_pixel),
    .cmd_push    (cmd_push),
    .cmd_flags   (fe_flags),
    .cmd_pixel   (fe_pixel),
    .cmd_pcol    (fe_pcol),
    .cmd_qcol    (fe_qcol),
    .low_thr     (low_thr),
    .high_thr    (high_thr)
  );

  // command queue between the front and back ends
  assign cq_wdata = {fe_flags, fe_pixel, fe_pcol, fe_qcol};
  assign {be_flags, be_pixel, be_pcol, be_qcol} = cq_rdata;

  snet_fifo #(
    .WIDTH (CQ_W),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cq_wdata),
    .pop   (cmd_pop),
    .rdata (cq_rdata),
    .empty (cq_empty),
    .full  (cq_full),
    .count (cq_count)
  );

  snet_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .OQ_DEPTH  (OQ_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cq_empty),
    .cmd_flags (be_flags),
    .cmd_pixel (be_pixel),
    .cmd_pcol  (be_pcol),
    .cmd_qcol  (be_qcol),
    .cmd_pop   (cmd_pop),
    .low_thr   (low_thr),
    .high_thr  (high_thr),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue; the back end only issues words it has room for
  snet_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push && !oq_full),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty),
    .full  (oq_full),
    .count (oq_count)
  );

  assign out_magnitude  = res_out.magnitude;
  assign out_sector     = res_out.sector;
  assign out_edge_class = res_out.edge_class;
  assign out_frame_last = res_out.frame_last;

  // command queue occupancy is only needed for the full flag
  logic cq_cnt_unused;
  assign cq_cnt_unused = ^cq_count;

endmodule

`default_nettype wire

### hdl/snet_fifo.sv
// snet_fifo: small synchronous queue with occupancy count
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module snet_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic                           pop,
  output logic      [WIDTH-1:0]               rdata,
  output logic                                empty,
  output logic                                full,
  output logic      [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == NW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/snet_front.sv
// snet_front: configuration registers, frame position counters and
// per-word classification; uses snet_pkg
`timescale 1ns / 1ps
`default_nettype none

module snet_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [snet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [snet_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_acc,
  input  wire logic                                in_req_type,
  input  wire logic [snet_pkg::PIX_W-1:0]          in_pixel,
  output logic                                     cmd_push,
  output snet_pkg::cmd_flags_t                     cmd_flags,
  output logic      [snet_pkg::PIX_W-1:0]          cmd_pixel,
  output logic      [$clog2(MAX_WIDTH)-1:0]        cmd_pcol,
  output logic      [$clog2(MAX_WIDTH)-1:0]        cmd_qcol,
  output logic      [snet_pkg::MAG_W-1:0]          low_thr,
  output logic      [snet_pkg::MAG_W-1:0]          high_thr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int KW = $clog2((MAX_HEIGHT + 2) * MAX_WIDTH + 2);

  logic [10:0]   width_r, low_r, high_r;
  logic [12:0]   height_r;
  logic [KW-1:0] k_r;
  logic [CW-1:0] kc_r, qc_r, tc_r;
  logic [RW-1:0] qr_r, tr_r;

  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [KW-1:0] wk, n, lim_pix, last;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1, hr;
  logic          pix_en, pix_wr, grad_en, out_ph, t_in, ignore;

  always_comb begin
    if (width_r == '0) eff_w = EW'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(width_r);
    if (height_r == '0) eff_h = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_r);
  end

  assign wk      = KW'(eff_w);
  assign n       = KW'(KW'(eff_w) * KW'(eff_h));
  assign lim_pix = n + wk;
  assign last    = n + wk + wk + KW'(1);
  assign wm1     = CW'(eff_w - EW'(1));
  assign hr      = RW'(eff_h);
  assign hm1     = hr - RW'(1);

  assign pix_en  = (k_r <= lim_pix);
  assign pix_wr  = (k_r < n);
  assign grad_en = (k_r > wk);
  assign out_ph  = (k_r >= wk + wk + KW'(2));
  assign t_in    = (tr_r < hr);
  // early drain before the frame is complete is dropped
  assign ignore  = (in_req_type == snet_pkg::REQ_DRAIN) && pix_wr;

  assign cmd_push  = in_acc && !ignore;
  assign cmd_pixel = in_pixel;
  assign cmd_pcol  = kc_r;
  assign cmd_qcol  = qc_r;
  assign low_thr   = low_r;
  assign high_thr  = high_r;

  always_comb begin
    cmd_flags.pix_en  = pix_en;
    cmd_flags.pix_wr  = pix_wr;
    cmd_flags.grad_en = grad_en;
    cmd_flags.q_valid = (qr_r < hr);
    cmd_flags.q_col0  = (qc_r == '0);
    cmd_flags.q_colw  = (qc_r == wm1);
    cmd_flags.q_row0  = (qr_r == '0);
    cmd_flags.q_rowh  = (qr_r == hm1);
    cmd_flags.out_en  = out_ph && t_in;
    cmd_flags.t_col0  = (tc_r == '0);
    cmd_flags.t_colw  = (tc_r == wm1);
    cmd_flags.t_row0  = (tr_r == '0);
    cmd_flags.t_rowh  = (tr_r == hm1);
    cmd_flags.t_last  = (tr_r == hm1) && (tc_r == wm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= snet_pkg::WIDTH_RST;
      height_r <= snet_pkg::HEIGHT_RST;
      low_r    <= snet_pkg::LOW_RST;
      high_r   <= snet_pkg::HIGH_RST;
      k_r      <= '0;
      kc_r     <= '0;
      qc_r     <= '0;
      qr_r     <= '0;
      tc_r     <= '0;
      tr_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        snet_pkg::REG_IMAGE_WIDTH: begin
          width_r <= cfg_data[10:0];
          k_r <= '0; kc_r <= '0; qc_r <= '0; qr_r <= '0; tc_r <= '0; tr_r <= '0;
        end
        snet_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= cfg_data[12:0];
          k_r <= '0; kc_r <= '0; qc_r <= '0; qr_r <= '0; tc_r <= '0; tr_r <= '0;
        end
        snet_pkg::REG_LOW_THRESHOLD:  low_r  <= cfg_data[10:0];
        snet_pkg::REG_HIGH_THRESHOLD: high_r <= cfg_data[10:0];
        default: ;
      endcase
    end else if (cmd_push) begin
      if (k_r >= last) begin
        k_r <= '0; kc_r <= '0; qc_r <= '0; qr_r <= '0; tc_r <= '0; tr_r <= '0;
      end else begin
        k_r  <= k_r + 1'b1;
        kc_r <= (kc_r == wm1) ? '0 : kc_r + 1'b1;
        if (grad_en) begin
          if (qc_r == wm1) begin
            qc_r <= '0;
            qr_r <= qr_r + 1'b1;
          end else begin
            qc_r <= qc_r + 1'b1;
          end
        end
        if (out_ph) begin
          if (tc_r == wm1) begin
            tc_r <= '0;
            tr_r <= tr_r + 1'b1;
          end else begin
            tc_r <= tc_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/snet_back.sv
// snet_back: line buffers, sobel, direction sectors, suppression and
// classing as a five stage pipeline; uses snet_pkg
`timescale 1ns / 1ps
`default_nettype none

module snet_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int OQ_DEPTH  = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cmd_empty,
  input  wire snet_pkg::cmd_flags_t                cmd_flags,
  input  wire logic [snet_pkg::PIX_W-1:0]          cmd_pixel,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        cmd_pcol,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]        cmd_qcol,
  output logic                                     cmd_pop,
  input  wire logic [snet_pkg::MAG_W-1:0]          low_thr,
  input  wire logic [snet_pkg::MAG_W-1:0]          high_thr,
  input  wire logic [$clog2(OQ_DEPTH+1)-1:0]       oq_count,
  output logic                                     res_push,
  output snet_pkg::res_t                           res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = snet_pkg::PIX_W;
  localparam int GW = snet_pkg::GRAD_W;
  localparam int MW = snet_pkg::MAG_W;

  // line buffers
  logic [PW-1:0] pl1_mem [MAX_WIDTH];
  logic [PW-1:0] pl2_mem [MAX_WIDTH];
  logic [GW-1:0] gl1_mem [MAX_WIDTH];
  logic [GW-1:0] gl2_mem [MAX_WIDTH];
  logic [PW-1:0] p1_rd_r, p2_rd_r;
  logic [GW-1:0] g1_rd_r, g2_rd_r;

  logic [PW-1:0] pwin_r [9];
  logic [GW-1:0] gwin_r [9];

  // stage 1
  logic                 s1_v_r, s1_byp_r;
  snet_pkg::cmd_flags_t s1_f_r;
  logic [PW-1:0]        s1_px_r, s1_btop_r, s1_bmid_r;
  logic [CW-1:0]        s1_col_r, s1_qcol_r;
  logic [PW-1:0]        top, mid, bot;
  // stage 2
  logic                 s2_v_r;
  snet_pkg::cmd_flags_t s2_f_r;
  logic [CW-1:0]        s2_qcol_r;
  logic [9:0]           ax, ay;
  logic                 sgx, sgy;
  // stage 3
  logic                 s3_v_r, s3_sgx_r, s3_sgy_r;
  snet_pkg::cmd_flags_t s3_f_r;
  logic [CW-1:0]        s3_qcol_r;
  logic [9:0]           s3_ax_r, s3_ay_r;
  logic [GW-1:0]        gnew;
  // stage 4
  logic                 s4_v_r, s4_byp_r;
  snet_pkg::cmd_flags_t s4_f_r;
  logic [CW-1:0]        s4_qcol_r;
  logic [GW-1:0]        s4_gnew_r, s4_btop_r, s4_bmid_r, gtop, gmid;
  logic                 s4_wr;
  // stage 5
  logic                 s5_v_r;
  snet_pkg::cmd_flags_t s5_f_r;

  logic [2:0]           inflight;

  // output room is reserved for every result-producing word still in the pipeline
  assign inflight = 3'(s1_v_r & s1_f_r.out_en) + 3'(s2_v_r & s2_f_r.out_en)
                  + 3'(s3_v_r & s3_f_r.out_en) + 3'(s4_v_r & s4_f_r.out_en)
                  + 3'(s5_v_r & s5_f_r.out_en);
  assign cmd_pop = !cmd_empty && ((32'(oq_count) + 32'(inflight)) < OQ_DEPTH);

  // ---- stage 1: pixel line buffers and pixel window
  assign top = s1_byp_r ? s1_btop_r : p2_rd_r;
  assign mid = s1_byp_r ? s1_bmid_r : p1_rd_r;
  assign bot = s1_f_r.pix_wr ? s1_px_r : mid;

  always_ff @(posedge clk) begin
    p1_rd_r <= pl1_mem[cmd_pcol];
    p2_rd_r <= pl2_mem[cmd_pcol];
    if (s1_v_r && s1_f_r.pix_wr) begin
      pl1_mem[s1_col_r] <= bot;
      pl2_mem[s1_col_r] <= mid;
    end
  end

  // ---- stage 2: sobel with replicated borders
  always_comb begin
    logic [PW-1:0] v [3][3];
    logic [11:0]   sr_sum, sl_sum, sb_sum, st_sum;
    logic signed [11:0] gx, gy;
    int sc, srw;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        sc  = c;
        srw = r;
        if (c == 0 && s2_f_r.q_col0) sc = 1;
        if (c == 2 && s2_f_r.q_colw) sc = 1;
        if (r == 0 && s2_f_r.q_row0) srw = 1;
        if (r == 2 && s2_f_r.q_rowh) srw = 1;
        v[r][c] = pwin_r[sc * 3 + srw];
      end
    end
    sr_sum = 12'(v[0][2]) + {3'b0, v[1][2], 1'b0} + 12'(v[2][2]);
    sl_sum = 12'(v[0][0]) + {3'b0, v[1][0], 1'b0} + 12'(v[2][0]);
    sb_sum = 12'(v[2][0]) + {3'b0, v[2][1], 1'b0} + 12'(v[2][2]);
    st_sum = 12'(v[0][0]) + {3'b0, v[0][1], 1'b0} + 12'(v[0][2]);
    gx  = signed'(sr_sum - sl_sum);
    gy  = signed'(sb_sum - st_sum);
    sgx = gx[11];
    sgy = gy[11];
    ax  = sgx ? 10'(-gx) : 10'(gx);
    ay  = sgy ? 10'(-gy) : 10'(gy);
  end

  // ---- stage 3: magnitude and direction sector
  always_comb begin
    logic [snet_pkg::PROD_W-1:0] lhs, plo, phi;
    logic [MW-1:0]               mag;
    logic [snet_pkg::SECT_W-1:0] sect;
    lhs = snet_pkg::PROD_W'(s3_ay_r) << snet_pkg::TAN_SHIFT;
    plo = snet_pkg::TAN_LO * snet_pkg::PROD_W'(s3_ax_r);
    phi = snet_pkg::TAN_HI * snet_pkg::PROD_W'(s3_ax_r);
    mag = MW'(s3_ax_r) + MW'(s3_ay_r);
    if (lhs <= plo) sect = snet_pkg::SECT_HORZ;
    else if (lhs > phi) sect = snet_pkg::SECT_VERT;
    else if (s3_sgx_r == s3_sgy_r) sect = snet_pkg::SECT_PLUS45;
    else sect = snet_pkg::SECT_MINUS45;
    gnew = s3_f_r.q_valid ? {sect, mag} : '0;
  end

  // ---- stage 4: gradient line buffers and gradient window
  assign gtop  = s4_byp_r ? s4_btop_r : g2_rd_r;
  assign gmid  = s4_byp_r ? s4_bmid_r : g1_rd_r;
  assign s4_wr = s4_v_r && s4_f_r.grad_en && s4_f_r.q_valid;

  always_ff @(posedge clk) begin
    g1_rd_r <= gl1_mem[s3_qcol_r];
    g2_rd_r <= gl2_mem[s3_qcol_r];
    if (s4_wr) begin
      gl1_mem[s4_qcol_r] <= s4_gnew_r;
      gl2_mem[s4_qcol_r] <= gmid;
    end
  end

  // ---- stage 5: suppression along the sector and classing
  always_comb begin
    logic [MW-1:0] g [3][3];
    logic [MW-1:0] m, s;
    logic          keep, outside;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        outside = (c == 0 && s5_f_r.t_col0) || (c == 2 && s5_f_r.t_colw) ||
                  (r == 0 && s5_f_r.t_row0) || (r == 2 && s5_f_r.t_rowh);
        g[r][c] = outside ? '0 : gwin_r[c * 3 + r][MW-1:0];
      end
    end
    m = g[1][1];
    case (gwin_r[4][GW-1:MW])
      snet_pkg::SECT_HORZ:    keep = (m > g[1][0]) && (m >= g[1][2]);
      snet_pkg::SECT_VERT:    keep = (m > g[0][1]) && (m >= g[2][1]);
      snet_pkg::SECT_MINUS45: keep = (m > g[0][2]) && (m > g[2][0]);
      default:                keep = (m > g[2][2]) && (m > g[0][0]);
    endcase
    s = keep ? m : '0;
    res.magnitude  = s;
    res.sector     = gwin_r[4][GW-1:MW];
    if (s >= high_thr) res.edge_class = snet_pkg::CLS_STRONG;
    else if (s < low_thr) res.edge_class = snet_pkg::CLS_NONE;
    else res.edge_class = snet_pkg::CLS_WEAK;
    res.frame_last = s5_f_r.t_last;
  end

  assign res_push = s5_v_r && s5_f_r.out_en;

  // ---- pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        pwin_r[i] <= '0;
        gwin_r[i] <= '0;
      end
    end else begin
      s1_v_r <= cmd_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      if (s1_v_r && s1_f_r.pix_en) begin
        for (int i = 0; i < 6; i++) pwin_r[i] <= pwin_r[i + 3];
        pwin_r[6] <= top;
        pwin_r[7] <= mid;
        pwin_r[8] <= bot;
      end
      if (s4_v_r && s4_f_r.grad_en) begin
        for (int i = 0; i < 6; i++) gwin_r[i] <= gwin_r[i + 3];
        gwin_r[6] <= gtop;
        gwin_r[7] <= gmid;
        gwin_r[8] <= s4_gnew_r;
      end
    end
  end

  // payload, with forwarding of a write to the same column in flight
  always_ff @(posedge clk) begin
    s1_f_r    <= cmd_flags;
    s1_px_r   <= cmd_pixel;
    s1_col_r  <= cmd_pcol;
    s1_qcol_r <= cmd_qcol;
    s1_byp_r  <= s1_v_r && s1_f_r.pix_wr && (s1_col_r == cmd_pcol);
    s1_btop_r <= mid;
    s1_bmid_r <= bot;
    s2_f_r    <= s1_f_r;
    s2_qcol_r <= s1_qcol_r;
    s3_f_r    <= s2_f_r;
    s3_qcol_r <= s2_qcol_r;
    s3_ax_r   <= ax;
    s3_ay_r   <= ay;
    s3_sgx_r  <= sgx;
    s3_sgy_r  <= sgy;
    s4_f_r    <= s3_f_r;
    s4_qcol_r <= s3_qcol_r;
    s4_gnew_r <= gnew;
    s4_byp_r  <= s4_wr && (s4_qcol_r == s3_qcol_r);
    s4_btop_r <= gmid;
    s4_bmid_r <= s4_gnew_r;
    s5_f_r    <= s4_f_r;
  end

endmodule

`default_nettype wire

### hdl/snet_chk.sv
// snet_chk: port level checks of the edge thinning unit, bound to the top
// depends on snet_pkg and sobel_nonmax_edge_thinning_unit
`timescale 1ns / 1ps
`default_nettype none

module snet_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              empty,
  input wire logic                              pop,
  input wire logic [snet_pkg::MAG_W-1:0]        out_magnitude,
  input wire logic [snet_pkg::SECT_W-1:0]       out_sector,
  input wire logic [snet_pkg::CLS_W-1:0]        out_edge_class,
  input wire logic                              out_frame_last
);

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> empty)
    else $error("result present right after reset");

  // a waiting result stays and holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_magnitude) && $stable(out_sector)
      && $stable(out_edge_class) && $stable(out_frame_last)))
    else $error("waiting result changed or vanished");

  // class code is one of the three defined classes
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_edge_class == snet_pkg::CLS_NONE ||
                out_edge_class == snet_pkg::CLS_WEAK ||
                out_edge_class == snet_pkg::CLS_STRONG))
    else $error("undefined edge class");

  // l1 sobel magnitude never exceeds its bound
  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_magnitude <= snet_pkg::MAG_MAX))
    else $error("magnitude out of range");

endmodule

bind sobel_nonmax_edge_thinning_unit snet_chk u_snet_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .empty          (empty),
  .pop            (pop),
  .out_magnitude  (out_magnitude),
  .out_sector     (out_sector),
  .out_edge_class (out_edge_class),
  .out_frame_last (out_frame_last)
);

`default_nettype wire

### test/sobel_nonmax_edge_thinning_unit_test.sv
// sobel_nonmax_edge_thinning_unit_test: self-checking testbench of the edge thinning block
// depends on snet_pkg and sobel_nonmax_edge_thinning_unit; uses no other file directly
`timescale 1ns / 1ps

module sobel_nonmax_edge_thinning_unit_test;
  import snet_pkg::*;

  localparam int LINE_MAX  = 1024;
  localparam int ROWS_MAX  = 4096;
  localparam int QUIET_CYC = 40;     // covers the internal pipeline after the last result
  localparam int WDOG_LIM  = 50000;  // idle cycles before giving up
  localparam int RAND_WORDS = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  // pixel content patterns for a frame
  typedef enum int {PAT_NOISE, PAT_BINARY, PAT_HRAMP, PAT_VRAMP, PAT_DIAG, PAT_FLAT} pat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_req_type = REQ_PIXEL;
  logic [PIX_W-1:0] in_pixel = '0;
  logic empty;
  logic pop = 1'b0;
  logic [MAG_W-1:0] out_magnitude;
  logic [SECT_W-1:0] out_sector;
  logic [CLS_W-1:0] out_edge_class;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  sobel_nonmax_edge_thinning_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_req_type(in_req_type), .in_pixel(in_pixel),
    .empty(empty), .pop(pop), .out_magnitude(out_magnitude), .out_sector(out_sector),
    .out_edge_class(out_edge_class), .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // edge thinning predictor: own copy of registers, line buffers and windows
  // ---------------------------------------------------------------------------
  logic [10:0] img_w_reg, lo_thr_reg, hi_thr_reg;
  logic [12:0] img_h_reg;
  logic [PIX_W-1:0]  pix_row1 [LINE_MAX];   // previous pixel row
  logic [PIX_W-1:0]  pix_row2 [LINE_MAX];   // row before that
  logic [GRAD_W-1:0] grad_row1 [LINE_MAX];  // magnitude plus sector on top
  logic [GRAD_W-1:0] grad_row2 [LINE_MAX];
  logic [PIX_W-1:0]  pix_win [9];           // col*3+row, col 2 newest
  logic [GRAD_W-1:0] grad_win [9];
  int unsigned frame_pos;

  res_t expected_results[$];
  int errors = 0;

  function automatic int unsigned eff_width();
    if (img_w_reg == 0) return 1;
    if (img_w_reg > LINE_MAX) return LINE_MAX;
    return img_w_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (img_h_reg == 0) return 1;
    if (img_h_reg > ROWS_MAX) return ROWS_MAX;
    return img_h_reg;
  endfunction

  function automatic void reset_predictor();
    img_w_reg = WIDTH_RST;
    img_h_reg = HEIGHT_RST;
    lo_thr_reg = LOW_RST;
    hi_thr_reg = HIGH_RST;
    foreach (pix_row1[i]) begin
      pix_row1[i] = '0; pix_row2[i] = '0; grad_row1[i] = '0; grad_row2[i] = '0;
    end
    foreach (pix_win[i]) begin
      pix_win[i] = '0; grad_win[i] = '0;
    end
    frame_pos = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w_reg = val[10:0]; frame_pos = 0;
      end
      REG_IMAGE_HEIGHT: begin
        img_h_reg = val[12:0]; frame_pos = 0;
      end
      REG_LOW_THRESHOLD: lo_thr_reg = val[10:0];
      REG_HIGH_THRESHOLD: hi_thr_reg = val[10:0];
      default: ;
    endcase
  endfunction

  // sobel gradient of the pixel window centred at (cc, cr), borders replicated
  function automatic logic [GRAD_W-1:0] sobel_at(int unsigned cc, int unsigned cr,
                                                  int unsigned w, int unsigned h);
    int v [3][3];
    int sc, sr, gx, gy;
    longint ax, ay, lhs;
    logic [SECT_W-1:0] sect;
    for (int col = 0; col < 3; col++) begin
      sc = col;
      if (col == 0 && cc == 0) sc = 1;
      if (col == 2 && cc == w - 1) sc = 1;
      for (int row = 0; row < 3; row++) begin
        sr = row;
        if (row == 0 && cr == 0) sr = 1;
        if (row == 2 && cr == h - 1) sr = 1;
        v[row][col] = pix_win[sc*3 + sr];
      end
    end
    gx = (v[0][2] + 2*v[1][2] + v[2][2]) - (v[0][0] + 2*v[1][0] + v[2][0]);
    gy = (v[2][0] + 2*v[2][1] + v[2][2]) - (v[0][0] + 2*v[0][1] + v[0][2]);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    lhs = ay << TAN_SHIFT;
    if (lhs <= longint'(TAN_LO) * ax) sect = SECT_HORZ;
    else if (lhs > longint'(TAN_HI) * ax) sect = SECT_VERT;
    else sect = ((gx >= 0) == (gy >= 0)) ? SECT_PLUS45 : SECT_MINUS45;
    return {sect, MAG_W'(ax + ay)};
  endfunction

  // advance the predictor by one accepted word; returns 1 when a result is due
  function automatic bit thin_step(logic req, logic [PIX_W-1:0] px, output res_t res);
    int unsigned w, h, n, last, k, c, q, cg, t, tc, tr;
    logic [PIX_W-1:0] top, mid, bot;
    logic [GRAD_W-1:0] gnew, gtop, gmid;
    logic [MAG_W-1:0] g [3][3];
    logic [MAG_W-1:0] m, s;
    logic [SECT_W-1:0] sect;
    bit keep, outside, got;
    w = eff_width(); h = eff_height(); n = w * h; last = n + 2*w + 1; k = frame_pos;
    got = 0;
    res = '0;
    if (k < n && req == REQ_DRAIN) return 0;
    if (k <= n + w) begin
      c = k % w;
      top = pix_row2[c]; mid = pix_row1[c];
      bot = (k < n) ? px : mid;
      if (k < n) begin
        pix_row2[c] = mid; pix_row1[c] = bot;
      end
      for (int i = 0; i < 6; i++) pix_win[i] = pix_win[i+3];
      pix_win[6] = top; pix_win[7] = mid; pix_win[8] = bot;
    end
    if (k >= w + 1) begin
      q = k - w - 1;
      cg = q % w;
      gnew = '0;
      if (q < n) gnew = sobel_at(cg, q / w, w, h);
      gtop = grad_row2[cg]; gmid = grad_row1[cg];
      if (q < n) begin
        grad_row2[cg] = gmid; grad_row1[cg] = gnew;
      end
      for (int i = 0; i < 6; i++) grad_win[i] = grad_win[i+3];
      grad_win[6] = gtop; grad_win[7] = gmid; grad_win[8] = gnew;
      if (q >= w + 1 && q - w - 1 < n) begin
        t = q - w - 1; tc = t % w; tr = t / w;
        for (int col = 0; col < 3; col++)
          for (int row = 0; row < 3; row++) begin
            outside = (col == 0 && tc == 0) || (col == 2 && tc == w - 1) ||
                      (row == 0 && tr == 0) || (row == 2 && tr == h - 1);
            g[row][col] = outside ? '0 : grad_win[col*3 + row][MAG_W-1:0];
          end
        m = g[1][1];
        sect = grad_win[4][GRAD_W-1:MAG_W];
        case (sect)
          SECT_HORZ:    keep = m > g[1][0] && m >= g[1][2];
          SECT_VERT:    keep = m > g[0][1] && m >= g[2][1];
          SECT_MINUS45: keep = m > g[0][2] && m > g[2][0];
          default:      keep = m > g[2][2] && m > g[0][0];
        endcase
        s = keep ? m : '0;
        res.magnitude = s;
        res.sector = sect;
        res.edge_class = (s >= hi_thr_reg) ? CLS_STRONG : ((s < lo_thr_reg) ? CLS_NONE : CLS_WEAK);
        res.frame_last = (t == n - 1);
        got = 1;
      end
    end
    frame_pos = (k >= last) ? 0 : k + 1;
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word, magnitude", out_magnitude, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_magnitude !== want.magnitude)
          report_mismatch("magnitude", out_magnitude, want.magnitude);
        if (out_sector !== want.sector) report_mismatch("sector", out_sector, want.sector);
        if (out_edge_class !== want.edge_class)
          report_mismatch("edge_class", out_edge_class, want.edge_class);
        if (out_frame_last !== want.frame_last)
          report_mismatch("frame_last", out_frame_last, want.frame_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random pop with short and long stalls, plus a long hold-off
  // ---------------------------------------------------------------------------
  bit rx_eager = 0;      // pop every cycle unless holding off or stalled
  int hold_request = 0;  // bumped by a test to ask for a long hold-off
  int hold_len = 0;
  int hold_seen = 0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      rx_hold_left = hold_len;
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      pop <= 1'b0;
    end else if (rx_eager) begin
      pop <= 1'b1;
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        rx_stall_left = (r < 95) ? $urandom_range(2, 0) : $urandom_range(40, 4);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any accepted word on either side
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIM) begin
        $display("watchdog: no word moved for %0d cycles", WDOG_LIM);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  bit tx_eager = 0;          // no gaps between words
  int counted_words = 0;     // words that the block does not merely ignore

  task automatic send_word(logic req, logic [PIX_W-1:0] px);
    int gap, r;
    res_t res;
    gap = 0;
    if (!tx_eager) begin
      r = $urandom_range(99);
      if (r >= 75) gap = (r < 96) ? $urandom_range(3, 1) : $urandom_range(40, 5);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_req_type <= req;
    in_pixel <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    // drain words ahead of the last pixel are dropped by the block
    if (!(req == REQ_DRAIN && frame_pos < eff_width() * eff_height())) counted_words++;
    if (thin_step(req, px, res)) expected_results = {expected_results, res};
  endtask

  // stop offering words and let every expected result come out
  task automatic wait_quiet();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(int wv, int hv);
    wait_quiet();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wv));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(pat_t pat, int idx, int w);
    int col, row;
    col = idx % w; row = idx / w;
    case (pat)
      PAT_BINARY: return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
      PAT_HRAMP:  return PIX_W'(col * 37 + $urandom_range(3));
      PAT_VRAMP:  return PIX_W'(row * 41 + $urandom_range(3));
      PAT_DIAG:   return PIX_W'((col + row) * 29 + ((col > row) ? 60 : 0));
      PAT_FLAT:   return 8'd128;
      default:    return PIX_W'($urandom);
    endcase
  endfunction

  // one frame of the current size: pixels then the flush words; optional
  // early drains (ignored) and pixel words in the tail (treated as drains)
  task automatic send_frame(pat_t pat, int noise_pct, int late_pct);
    int w, n;
    w = eff_width(); n = w * eff_height();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_word(REQ_DRAIN, PIX_W'($urandom));
      send_word(REQ_PIXEL, pick_pixel(pat, i, w));
    end
    for (int i = 0; i < 2*w + 2; i++) begin
      if ($urandom_range(99) < late_pct) send_word(REQ_PIXEL, PIX_W'($urandom));
      else send_word(REQ_DRAIN, PIX_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 3x3 frame of extreme pixels: early drain ignored, late pixel acts as drain
  task automatic test_directed_small();
    logic [PIX_W-1:0] pix [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255};
    set_size(3, 3);
    write_reg(REG_LOW_THRESHOLD, 13'd20);
    write_reg(REG_HIGH_THRESHOLD, 13'd600);
    write_reg(REG_UNUSED, 13'h1fff);  // index past the register file, no effect
    send_word(REQ_DRAIN, 8'hff);
    foreach (pix[i]) send_word(REQ_PIXEL, pix[i]);
    send_word(REQ_PIXEL, 8'hff);
    for (int i = 0; i < 7; i++) send_word(REQ_DRAIN, 8'h00);
  endtask

  // size corners: zero width, oversized width and height cut short by a
  // restart, and a wider frame
  task automatic test_size_extremes();
    set_size(0, 2);
    send_frame(PAT_BINARY, 0, 0);
    // oversized width acts as the widest line; no result before the restart
    set_size(2047, 1);
    write_reg(REG_LOW_THRESHOLD, 13'd0);
    write_reg(REG_HIGH_THRESHOLD, 13'd0);
    for (int i = 0; i < 300; i++) send_word(REQ_PIXEL, PIX_W'($urandom));
    // oversized height on a one pixel wide column, part of a frame
    set_size(1, 8191);
    write_reg(REG_LOW_THRESHOLD, 13'd2047);
    write_reg(REG_HIGH_THRESHOLD, 13'd2047);
    for (int i = 0; i < 300; i++) send_word(REQ_PIXEL, pick_pixel(PAT_VRAMP, i, 1));
    set_size(64, 3);
    write_reg(REG_LOW_THRESHOLD, 13'd40);
    write_reg(REG_HIGH_THRESHOLD, 13'd200);
    send_frame(PAT_DIAG, 0, 0);
  endtask

  // long receiver hold-off while words keep coming back to back
  task automatic test_backpressure();
    set_size(16, 6);
    hold_len = 400;
    hold_request++;
    tx_eager = 1;
    send_frame(PAT_NOISE, 0, 0);
    tx_eager = 0;
    wait_quiet();
  endtask

  // size write in the middle of a frame restarts it
  task automatic test_abort();
    set_size(5, 4);
    for (int i = 0; i < 13; i++) send_word(REQ_PIXEL, PIX_W'($urandom));
    wait_quiet();
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    send_frame(PAT_HRAMP, 0, 0);
  endtask

  // random frames of mostly small sizes with random thresholds
  task automatic test_random_frames();
    int start, w, h, lo, hi;
    pat_t pat;
    start = counted_words;
    while (counted_words - start < RAND_WORDS) begin
      if ($urandom_range(99) < 40) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        h = $urandom_range(8, 1);
        lo = ($urandom_range(5) == 0) ? 0 : $urandom_range(300);
        hi = ($urandom_range(5) == 0) ? 2047 : $urandom_range(800);
        set_size(w, h);
        write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'(lo));
        write_reg(REG_HIGH_THRESHOLD, CFG_DATA_W'(hi));
      end
      tx_eager = ($urandom_range(4) == 0);
      rx_eager = ($urandom_range(4) == 0);
      pat = pat_t'($urandom_range(5));
      if ($urandom_range(19) == 0) begin
        // broken sequence: part of a frame, then a restart by width write
        for (int i = 0; i < $urandom_range(eff_width() * eff_height(), 1); i++)
          send_word(REQ_PIXEL, PIX_W'($urandom));
        tx_eager = 0;
        wait_quiet();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(img_w_reg));
      end else begin
        send_frame(pat, ($urandom_range(3) == 0) ? 5 : 0, ($urandom_range(3) == 0) ? 10 : 0);
      end
    end
    tx_eager = 0;
    rx_eager = 0;
  endtask

  initial begin
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_small();
    test_size_extremes();
    test_backpressure();
    test_abort();
    test_random_frames();
    wait_quiet();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
